// ----- rtl/core/rtos_task_scheduler_defines.svh -----
// assertion macros shared by the scheduler rtl
`ifndef RTOS_TASK_SCHEDULER_DEFINES_SVH
`define RTOS_TASK_SCHEDULER_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define RTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rts check failed");

// implication whose consequent is checked in the next cycle
`define RTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rts check failed");

`endif

// ----- rtl/core/rts_pkg.sv -----
// ----------------------------------------------------------------------------
// rts_pkg
// types and constants of the task scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package rts_pkg;
	localparam int TASKS_DEF = 16;
	localparam int SEMS_DEF = 8;
	localparam int EVTS_DEF = 8;
	localparam int FLAGS_DEF = 16;
	localparam logic [7:0] IDLE_PRIO = 8'd100;

	typedef enum logic [3:0] {
		OP_CREATE = 4'd0, OP_DELAY = 4'd1, OP_TICK = 4'd2, OP_SEM_CREATE = 4'd3,
		OP_SEM_PEND = 4'd4, OP_SEM_POST = 4'd5, OP_EVT_CREATE = 4'd6,
		OP_EVT_PEND = 4'd7, OP_EVT_SET = 4'd8, OP_EVT_RESET = 4'd9,
		OP_ISR_ENTER = 4'd10, OP_ISR_EXIT = 4'd11, OP_START = 4'd12
	} op_t;

	localparam logic [2:0] ST_FREE = 3'd0;
	localparam logic [2:0] ST_READY = 3'd1;
	localparam logic [2:0] ST_DELAYED = 3'd2;
	localparam logic [2:0] ST_SEMWAIT = 3'd3;
	localparam logic [2:0] ST_EVTWAIT = 3'd4;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_REFUSED = 2'd2;

	typedef struct packed {
		logic [3:0] operation;
		logic [7:0] priority_req;
		logic [15:0] delay_ticks;
		logic [2:0] object_index;
		logic [14:0] initial_value;
		logic [15:0] event_mask;
		logic wait_all;
	} cmd_t;

	typedef struct packed {
		logic [3:0] running_task;
		logic task_switch;
		logic [3:0] new_index;
		logic [1:0] status;
		logic [15:0] event_value;
		logic [31:0] tick_count;
	} rsp_t;
endpackage
`default_nettype wire

// ----- rtl/core/rtos_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// rtos_task_scheduler
// priority preemptive task manager, task table kept in a synchronous memory
// ----------------------------------------------------------------------------
// channel   ports                  handshake
// command   start, busy, cmd       taken when start & !busy
// result    done, rsp              one cycle strobe, no backpressure
//
// each command sweeps the task table memory one slot at a time (read, then
// write back) while the best ready task is tracked, and done follows the sweep.
// create and sem post sweep twice, first to find a free slot or the most
// urgent waiter.
// busy is high from accept until done; a new word can be taken in the done cycle.
// reset marks every slot free, and slot 0 ready at the idle priority, before the first command.
// the receiver cannot stall; done lasts one cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "rtos_task_scheduler_defines.svh"
module rtos_task_scheduler import rts_pkg::*; #(
	parameter int TASKS = TASKS_DEF,
	parameter int SEMAPHORES = SEMS_DEF,
	parameter int EVENT_GROUPS = EVTS_DEF,
	parameter int FLAG_BITS = FLAGS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire cmd_t cmd,
	output logic done,
	output rsp_t rsp
);
	localparam int TW = $clog2(TASKS);
	localparam int SW = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
	localparam int EW = (EVENT_GROUPS > 1) ? $clog2(EVENT_GROUPS) : 1;
	localparam logic [15:0] FMASK = 16'((32'hFFFF_FFFF) >> (32 - FLAG_BITS));

	typedef struct packed {
		logic [7:0] prio;
		logic [2:0] st;
		logic [15:0] dly;
		logic [2:0] wobj;
		logic [15:0] wbits;
		logic wall;
	} tent_t;

	typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_MOD, S_DONE} state_t;

	tent_t mem [TASKS];
	tent_t rd_q;
	logic [15:0] sem_mem [SEMAPHORES];
	logic [15:0] evt_q [EVENT_GROUPS];

	state_t state_q;
	logic [TW:0] idx_q;
	cmd_t c_q;
	logic [SW:0] sems_q;
	logic [EW:0] evts_q;
	logic [TW-1:0] cur_q, best_q, wake_q, fre_q;
	logic best_v_q, wake_v_q, fre_v_q;
	logic [7:0] best_p_q, wake_p_q, isr_q;
	logic started_q;
	logic [31:0] ticks_q;
	logic [1:0] stat_q;
	logic [15:0] ev_q, semv_q;
	logic [3:0] newi_q;
	logic blk_q, pass_q;

	// command decode, from the registered command
	logic [15:0] mask;
	logic may_block;
	logic sem_ok, evt_ok;
	logic [SW-1:0] so;
	logic [EW-1:0] eo;
	assign mask = c_q.event_mask & FMASK;
	assign may_block = started_q && isr_q == 8'd0 && cur_q != '0;
	assign sem_ok = {1'b0, 32'(c_q.object_index)} < {1'b0, 32'(sems_q)} &&
		32'(c_q.object_index) < SEMAPHORES;
	assign evt_ok = {1'b0, 32'(c_q.object_index)} < {1'b0, 32'(evts_q)} &&
		32'(c_q.object_index) < EVENT_GROUPS;
	assign so = SW'(c_q.object_index);
	assign eo = EW'(c_q.object_index);

	function automatic logic cond(input logic [15:0] b, input logic [15:0] m,
		input logic a);
		cond = a ? ((b & m) == m) : ((b & m) != 16'd0);
	endfunction

	logic [TW-1:0] slot;
	assign slot = idx_q[TW-1:0];

	// modified entry during the sweep
	tent_t nx;
	logic is_cur;
	always_comb begin
		nx = rd_q;
		is_cur = slot == cur_q;
		case (op_t'(c_q.operation))
			OP_CREATE: if (fre_v_q && slot == fre_q) begin
				nx.prio = c_q.priority_req; nx.st = ST_READY; nx.dly = 16'd0;
			end
			OP_DELAY: if (blk_q && is_cur) begin
				nx.dly = c_q.delay_ticks; nx.st = ST_DELAYED;
			end
			OP_TICK: if (rd_q.st == ST_DELAYED) begin
				if (rd_q.dly > 16'd0) nx.dly = rd_q.dly - 16'd1;
				if (rd_q.dly <= 16'd1) nx.st = ST_READY;
			end
			OP_SEM_PEND: if (blk_q && is_cur) begin
				nx.wobj = c_q.object_index; nx.st = ST_SEMWAIT;
			end
			OP_SEM_POST: if (sem_ok && wake_v_q && slot == wake_q) nx.st = ST_READY;
			OP_EVT_PEND: if (blk_q && is_cur) begin
				nx.wobj = c_q.object_index; nx.wbits = mask;
				nx.wall = c_q.wait_all; nx.st = ST_EVTWAIT;
			end
			OP_EVT_SET: if (evt_ok && rd_q.st == ST_EVTWAIT &&
				rd_q.wobj == c_q.object_index && cond(ev_q, rd_q.wbits, rd_q.wall))
				nx.st = ST_READY;
			default: ;
		endcase
	end

	// registered semaphore read, addressed by the incoming word
	logic [15:0] sem_rd_q;

	always_ff @(posedge clk) begin
		if (state_q == S_RD) rd_q <= mem[slot];
		if (state_q == S_CLR) mem[slot].st <= (slot == '0) ? ST_READY : ST_FREE;
		if (state_q == S_CLR && slot == '0) mem[slot].prio <= IDLE_PRIO;
		if (state_q == S_MOD && !pass_q) mem[slot] <= nx;
		if (state_q == S_IDLE) sem_rd_q <= sem_mem[SW'(cmd.object_index)];
		if (state_q == S_IDLE && start && op_t'(cmd.operation) == OP_SEM_CREATE &&
			32'(sems_q) < SEMAPHORES)
			sem_mem[SW'(sems_q)] <= 16'(cmd.initial_value);
		if (state_q == S_DONE && stat_q == STAT_OK && sem_ok) begin
			if (op_t'(c_q.operation) == OP_SEM_PEND && semv_q != 16'd0)
				sem_mem[so] <= semv_q - 16'd1;
			if (op_t'(c_q.operation) == OP_SEM_POST && !wake_v_q && semv_q != 16'hFFFF)
				sem_mem[so] <= semv_q + 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR; idx_q <= '0; sems_q <= '0; evts_q <= '0;
			cur_q <= '0; isr_q <= '0; started_q <= 1'b0; ticks_q <= 32'd1;
			done <= 1'b0; busy <= 1'b1; rsp <= '0;
			best_q <= '0; best_v_q <= 1'b0; best_p_q <= '0;
			wake_q <= '0; wake_v_q <= 1'b0; wake_p_q <= '0;
			fre_q <= '0; fre_v_q <= 1'b0; pass_q <= 1'b0;
			stat_q <= STAT_OK; ev_q <= '0; semv_q <= '0; newi_q <= '0; blk_q <= 1'b0;
			c_q <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == (TW+1)'(TASKS - 1)) begin
						state_q <= S_IDLE; busy <= 1'b0;
					end
				end
				S_IDLE: if (start) begin
					c_q <= cmd; busy <= 1'b1; idx_q <= '0;
					best_v_q <= 1'b0; wake_v_q <= 1'b0; fre_v_q <= 1'b0;
					state_q <= S_RD;
					// first pass finds free slot and best semaphore waiter
					pass_q <= op_t'(cmd.operation) == OP_CREATE ||
						op_t'(cmd.operation) == OP_SEM_POST;
					stat_q <= STAT_OK; newi_q <= '0; ev_q <= '0; blk_q <= 1'b0;
					case (op_t'(cmd.operation))
						OP_DELAY: ;
						default: ;
					endcase
				end
				S_RD: begin
					state_q <= S_MOD;
					if (idx_q == '0 && !pass_q) begin
						// decide once per command, before writes
						semv_q <= sem_rd_q;
						case (op_t'(c_q.operation))
							OP_CREATE: if (!fre_v_q) stat_q <= STAT_FULL;
								else newi_q <= 4'(fre_q);
							OP_DELAY: if (c_q.delay_ticks != 16'd0) begin
								if (may_block) blk_q <= 1'b1; else stat_q <= STAT_REFUSED;
							end
							OP_TICK: ticks_q <= ticks_q + 32'd1;
							OP_SEM_CREATE: if (32'(sems_q) >= SEMAPHORES) stat_q <= STAT_FULL;
								else begin newi_q <= 4'(sems_q); sems_q <= sems_q + 1'b1; end
							OP_SEM_PEND: if (!sem_ok) stat_q <= STAT_REFUSED;
								else if (sem_rd_q == 16'd0) begin
									if (may_block) blk_q <= 1'b1; else stat_q <= STAT_REFUSED;
								end
							OP_SEM_POST: if (!sem_ok) stat_q <= STAT_REFUSED;
							OP_EVT_CREATE: if (32'(evts_q) >= EVENT_GROUPS) stat_q <= STAT_FULL;
								else begin
									newi_q <= 4'(evts_q); evts_q <= evts_q + 1'b1;
									evt_q[EW'(evts_q)] <= 16'(c_q.initial_value) & FMASK;
									ev_q <= 16'(c_q.initial_value) & FMASK;
								end
							OP_EVT_PEND: if (!evt_ok) stat_q <= STAT_REFUSED;
								else begin
									ev_q <= evt_q[eo];
									if (!cond(evt_q[eo], mask, c_q.wait_all)) begin
										if (may_block) blk_q <= 1'b1; else stat_q <= STAT_REFUSED;
									end
								end
							OP_EVT_SET: if (!evt_ok) stat_q <= STAT_REFUSED;
								else begin
									evt_q[eo] <= evt_q[eo] | mask; ev_q <= evt_q[eo] | mask;
								end
							OP_EVT_RESET: if (!evt_ok) stat_q <= STAT_REFUSED;
								else begin
									evt_q[eo] <= evt_q[eo] & ~mask; ev_q <= evt_q[eo] & ~mask;
								end
							OP_ISR_ENTER: if (isr_q != 8'hFF) isr_q <= isr_q + 8'd1;
							OP_ISR_EXIT: if (isr_q == 8'd0) stat_q <= STAT_REFUSED;
								else isr_q <= isr_q - 8'd1;
							OP_START: started_q <= 1'b1;
							default: stat_q <= STAT_REFUSED;
						endcase
					end
				end
				S_MOD: begin
					if (pass_q) begin
						if (slot != '0 && rd_q.st == ST_FREE && !fre_v_q) begin
							fre_v_q <= 1'b1; fre_q <= slot;
						end
						if (rd_q.st == ST_SEMWAIT && rd_q.wobj == c_q.object_index &&
							(!wake_v_q || rd_q.prio < wake_p_q)) begin
							wake_v_q <= 1'b1; wake_q <= slot; wake_p_q <= rd_q.prio;
						end
					end else if (nx.st == ST_READY && (!best_v_q || nx.prio < best_p_q)) begin
						best_v_q <= 1'b1; best_q <= slot; best_p_q <= nx.prio;
					end
					if (idx_q == (TW+1)'(TASKS - 1)) begin
						idx_q <= '0;
						if (pass_q) begin
							pass_q <= 1'b0; state_q <= S_RD;
						end else state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1; state_q <= S_RD;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE; busy <= 1'b0; done <= 1'b1;
					if (started_q && isr_q == 8'd0) begin
						cur_q <= best_v_q ? best_q : '0;
						rsp.running_task <= 4'(best_v_q ? best_q : '0);
						rsp.task_switch <= (best_v_q ? best_q : '0) != cur_q;
					end else begin
						rsp.task_switch <= 1'b0; rsp.running_task <= 4'(cur_q);
					end
					rsp.new_index <= newi_q; rsp.status <= stat_q;
					rsp.event_value <= ev_q; rsp.tick_count <= ticks_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RTS_ASSERT_IMP(a_busy_done, clk, arst_n, done, !busy)
	`RTS_ASSERT_NEXT(a_take_busy, clk, arst_n, start && !busy, busy)
	`RTS_ASSERT_IMP(a_stat_rng, clk, arst_n, done, rsp.status != 2'd3)
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the task scheduler: commands are run through a
// behavioral predictor as they are accepted, results checked field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
	import rts_pkg::*;

	localparam int NTASK = 16;
	localparam int NSEM = 8;
	localparam int NEVT = 8;
	localparam int RANDOM_WORDS = 700;
	localparam int QUIET_WORDS = 100;
	localparam int STALL_LIMIT = 2000;

	class sched_scoreboard;
		logic [7:0] prio[NTASK];
		logic [2:0] tstat[NTASK];
		logic [15:0] dly_left[NTASK];
		logic [2:0] wobj[NTASK];
		logic [15:0] wbits[NTASK];
		logic wall[NTASK];
		logic [15:0] sem_cnt[NSEM];
		int sems_used;
		logic [15:0] evt_bits[NEVT];
		int evts_used;
		int cur_task;
		int isr_depth;
		bit started;
		logic [31:0] ticks;
		rsp_t pending[$];
		int errors;

		function new();
			for (int i = 0; i < NTASK; i++) begin
				prio[i] = '0;
				tstat[i] = ST_FREE;
				dly_left[i] = '0;
				wobj[i] = '0;
				wbits[i] = '0;
				wall[i] = 1'b0;
			end
			for (int i = 0; i < NSEM; i++) sem_cnt[i] = '0;
			for (int i = 0; i < NEVT; i++) evt_bits[i] = '0;
			prio[0] = IDLE_PRIO;
			tstat[0] = ST_READY;
			sems_used = 0;
			evts_used = 0;
			cur_task = 0;
			isr_depth = 0;
			started = 1'b0;
			ticks = 32'd1;
			errors = 0;
		endfunction

		function bit cond_holds(logic [15:0] bits, logic [15:0] mask, logic all);
			if (all) return (bits & mask) == mask;
			return (bits & mask) != 0;
		endfunction

		function bit can_block();
			return started && isr_depth == 0 && cur_task != 0;
		endfunction

		function int most_urgent();
			int best;
			best = 0;
			for (int i = 0; i < NTASK; i++)
				if (tstat[i] == ST_READY && (tstat[best] != ST_READY || prio[i] < prio[best]))
					best = i;
			return best;
		endfunction

		// runs one command through the predictor, queues its result
		function void note_cmd(cmd_t c);
			rsp_t r;
			int prev, slot, waker;
			logic [2:0] obj;
			prev = cur_task;
			obj = c.object_index;
			r = '0;
			r.status = STAT_OK;
			case (c.operation)
				OP_CREATE: begin
					slot = 0;
					for (int i = NTASK - 1; i >= 1; i--)
						if (tstat[i] == ST_FREE) slot = i;
					if (slot == 0) r.status = STAT_FULL;
					else begin
						prio[slot] = c.priority_req;
						tstat[slot] = ST_READY;
						dly_left[slot] = '0;
						r.new_index = 4'(slot);
					end
				end
				OP_DELAY: begin
					if (c.delay_ticks != 0) begin
						if (!can_block()) r.status = STAT_REFUSED;
						else begin
							dly_left[cur_task] = c.delay_ticks;
							tstat[cur_task] = ST_DELAYED;
						end
					end
				end
				OP_TICK: begin
					ticks = ticks + 1;
					for (int i = 0; i < NTASK; i++)
						if (tstat[i] == ST_DELAYED) begin
							if (dly_left[i] != 0) dly_left[i]--;
							if (dly_left[i] == 0) tstat[i] = ST_READY;
						end
				end
				OP_SEM_CREATE: begin
					if (sems_used >= NSEM) r.status = STAT_FULL;
					else begin
						sem_cnt[sems_used] = {1'b0, c.initial_value};
						r.new_index = 4'(sems_used);
						sems_used++;
					end
				end
				OP_SEM_PEND: begin
					if (obj >= sems_used) r.status = STAT_REFUSED;
					else if (sem_cnt[obj] != 0) sem_cnt[obj]--;
					else if (!can_block()) r.status = STAT_REFUSED;
					else begin
						wobj[cur_task] = obj;
						tstat[cur_task] = ST_SEMWAIT;
					end
				end
				OP_SEM_POST: begin
					if (obj >= sems_used) r.status = STAT_REFUSED;
					else begin
						waker = -1;
						for (int i = 0; i < NTASK; i++)
							if (tstat[i] == ST_SEMWAIT && wobj[i] == obj &&
								(waker < 0 || prio[i] < prio[waker]))
								waker = i;
						if (waker >= 0) tstat[waker] = ST_READY;
						else if (sem_cnt[obj] != 16'hFFFF) sem_cnt[obj]++;
					end
				end
				OP_EVT_CREATE: begin
					if (evts_used >= NEVT) r.status = STAT_FULL;
					else begin
						evt_bits[evts_used] = {1'b0, c.initial_value};
						r.new_index = 4'(evts_used);
						r.event_value = evt_bits[evts_used];
						evts_used++;
					end
				end
				OP_EVT_PEND: begin
					if (obj >= evts_used) r.status = STAT_REFUSED;
					else begin
						r.event_value = evt_bits[obj];
						if (!cond_holds(evt_bits[obj], c.event_mask, c.wait_all)) begin
							if (!can_block()) r.status = STAT_REFUSED;
							else begin
								wobj[cur_task] = obj;
								wbits[cur_task] = c.event_mask;
								wall[cur_task] = c.wait_all;
								tstat[cur_task] = ST_EVTWAIT;
							end
						end
					end
				end
				OP_EVT_SET: begin
					if (obj >= evts_used) r.status = STAT_REFUSED;
					else begin
						evt_bits[obj] |= c.event_mask;
						r.event_value = evt_bits[obj];
						for (int i = 0; i < NTASK; i++)
							if (tstat[i] == ST_EVTWAIT && wobj[i] == obj &&
								cond_holds(evt_bits[obj], wbits[i], wall[i]))
								tstat[i] = ST_READY;
					end
				end
				OP_EVT_RESET: begin
					if (obj >= evts_used) r.status = STAT_REFUSED;
					else begin
						evt_bits[obj] &= ~c.event_mask;
						r.event_value = evt_bits[obj];
					end
				end
				OP_ISR_ENTER: if (isr_depth < 255) isr_depth++;
				OP_ISR_EXIT: begin
					if (isr_depth == 0) r.status = STAT_REFUSED;
					else isr_depth--;
				end
				OP_START: started = 1'b1;
				default: r.status = STAT_REFUSED;
			endcase
			if (started && isr_depth == 0) cur_task = most_urgent();
			r.running_task = 4'(cur_task);
			r.task_switch = cur_task != prev;
			r.tick_count = ticks;
			pending.push_back(r);
		endfunction

		function void check_rsp(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result word %h", got);
				return;
			end
			want = pending.pop_front();
			if (got.running_task !== want.running_task ||
				got.task_switch !== want.task_switch ||
				got.new_index !== want.new_index || got.status !== want.status ||
				got.event_value !== want.event_value ||
				got.tick_count !== want.tick_count) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch exp/got: run %0d/%0d sw %0b/%0b idx %0d/%0d",
						want.running_task, got.running_task, want.task_switch,
						got.task_switch, want.new_index, got.new_index);
					$display("  st %0d/%0d evt %h/%h ticks %0d/%0d",
						want.status, got.status, want.event_value, got.event_value,
						want.tick_count, got.tick_count);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy;
	logic done;
	rsp_t rsp;
	sched_scoreboard sb = new();
	int quiet_cycles = 0;

	rtos_task_scheduler dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .rsp(rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) sb.check_rsp(rsp);
	end

	// watchdog: no command taken and no result seen for too long
	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic cmd_t make_cmd(logic [3:0] op, logic [7:0] pr, logic [15:0] dl,
		logic [2:0] obj, logic [14:0] init, logic [15:0] mask, logic all);
		cmd_t c;
		c.operation = op;
		c.priority_req = pr;
		c.delay_ticks = dl;
		c.object_index = obj;
		c.initial_value = init;
		c.event_mask = mask;
		c.wait_all = all;
		return c;
	endfunction

	// mostly well-formed kernel traffic, with the odd unknown code
	function automatic cmd_t random_cmd();
		cmd_t c;
		int pick;
		c = make_cmd(4'($urandom_range(0, 15)), 8'($urandom), 16'($urandom), 3'($urandom),
			15'($urandom), 16'($urandom), 1'($urandom));
		pick = $urandom_range(0, 99);
		if (pick < 20) c.operation = OP_TICK;
		else if (pick < 32) c.operation = OP_DELAY;
		else if (pick < 44) c.operation = OP_SEM_PEND;
		else if (pick < 56) c.operation = OP_SEM_POST;
		else if (pick < 66) c.operation = OP_EVT_PEND;
		else if (pick < 76) c.operation = OP_EVT_SET;
		else if (pick < 81) c.operation = OP_EVT_RESET;
		else if (pick < 86) c.operation = OP_CREATE;
		else if (pick < 88) c.operation = OP_SEM_CREATE;
		else if (pick < 90) c.operation = OP_EVT_CREATE;
		else if (pick < 94) c.operation = OP_ISR_ENTER;
		else if (pick < 98) c.operation = OP_ISR_EXIT;
		else if (pick < 99) c.operation = OP_START;
		// short sleeps so delayed tasks come back
		if ($urandom_range(0, 9) != 0) c.delay_ticks = 16'($urandom_range(0, 6));
		if ($urandom_range(0, 1)) c.event_mask = 16'(1 << $urandom_range(0, 15));
		if ($urandom_range(0, 3) != 0) c.initial_value = 15'($urandom_range(0, 3));
		if ($urandom_range(0, 3) != 0) c.object_index = 3'($urandom_range(0, 2));
		return c;
	endfunction

	// start stays high from one word to the next unless sender_gap drops it
	task automatic send(cmd_t c);
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		sb.note_cmd(c);
	endtask

	task automatic sender_gap();
		int n;
		n = $urandom_range(1, 9);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	initial begin
		int waited;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: error paths before start, creates at the priority extremes
		send(make_cmd(OP_SEM_PEND, 8'd0, 16'd0, 3'd0, 15'd0, 16'h0000, 1'b0));
		send(make_cmd(OP_ISR_EXIT, 8'd0, 16'd0, 3'd0, 15'd0, 16'h0000, 1'b0));
		send(make_cmd(4'd13, 8'd0, 16'd0, 3'd0, 15'd0, 16'h0000, 1'b0));
		send(make_cmd(4'd15, 8'hFF, 16'hFFFF, 3'd7, 15'h7FFF, 16'hFFFF, 1'b1));
		send(make_cmd(OP_DELAY, 8'd0, 16'd5, 3'd0, 15'd0, 16'h0000, 1'b0));
		send(make_cmd(OP_CREATE, 8'd0, 16'd0, 3'd0, 15'd0, 16'h0000, 1'b0));
		send(make_cmd(OP_CREATE, 8'd255, 16'd0, 3'd0, 15'd0, 16'h0000, 1'b0));
		send(make_cmd(OP_CREATE, IDLE_PRIO, 16'd0, 3'd0, 15'd0, 16'h0000, 1'b0));
		send(make_cmd(OP_SEM_CREATE, 8'd0, 16'd0, 3'd0, 15'd0, 16'h0000, 1'b0));
		send(make_cmd(OP_SEM_CREATE, 8'd0, 16'd0, 3'd0, 15'h7FFF, 16'h0000, 1'b0));
		send(make_cmd(OP_EVT_CREATE, 8'd0, 16'd0, 3'd0, 15'h7FFF, 16'h0000, 1'b0));
		send(make_cmd(OP_EVT_PEND, 8'd0, 16'd0, 3'd0, 15'd0, 16'h0000, 1'b0));
		send(make_cmd(OP_START, 8'd0, 16'd0, 3'd0, 15'd0, 16'h0000, 1'b0));
		send(make_cmd(OP_START, 8'd0, 16'd0, 3'd0, 15'd0, 16'h0000, 1'b0));
		// most urgent task blocks on an empty semaphore, then a post hands it back
		send(make_cmd(OP_SEM_PEND, 8'd0, 16'd0, 3'd0, 15'd0, 16'h0000, 1'b0));
		send(make_cmd(OP_SEM_POST, 8'd0, 16'd0, 3'd0, 15'd0, 16'h0000, 1'b0));
		// empty any-mask is never met, so this blocks
		send(make_cmd(OP_EVT_PEND, 8'd0, 16'd0, 3'd0, 15'd0, 16'h0000, 1'b0));
		send(make_cmd(OP_EVT_SET, 8'd0, 16'd0, 3'd0, 15'd0, 16'hFFFF, 1'b0));
		send(make_cmd(OP_EVT_RESET, 8'd0, 16'd0, 3'd0, 15'd0, 16'hFFFF, 1'b0));
		send(make_cmd(OP_EVT_PEND, 8'd0, 16'd0, 3'd0, 15'd0, 16'hFFFF, 1'b1));
		send(make_cmd(OP_ISR_ENTER, 8'd0, 16'd0, 3'd0, 15'd0, 16'h0000, 1'b0));
		send(make_cmd(OP_DELAY, 8'd0, 16'hFFFF, 3'd0, 15'd0, 16'h0000, 1'b0));
		send(make_cmd(OP_ISR_EXIT, 8'd0, 16'd0, 3'd0, 15'd0, 16'h0000, 1'b0));
		send(make_cmd(OP_DELAY, 8'd0, 16'd1, 3'd0, 15'd0, 16'h0000, 1'b0));
		send(make_cmd(OP_TICK, 8'd0, 16'd0, 3'd0, 15'd0, 16'h0000, 1'b0));
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n < RANDOM_WORDS - QUIET_WORDS && $urandom_range(0, 3) == 0) sender_gap();
			send(random_cmd());
		end
		start <= 1'b0;
		waited = 0;
		while (sb.pending.size() != 0 && waited < STALL_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/rts_pkg.sv
rtl/core/rtos_task_scheduler.sv
sim/tb.sv
